[rtl/cmra_pkg.sv]
// Package for the centroid / max-radius area block.
// Holds sizing constants, the pi constant and the item types shared by all rtl files.
// No dependencies.
package cmra_pkg;

    // Point store and set sizing
    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Coordinate and arithmetic widths
    localparam int COORD_W = 20;
    localparam int SUM_W   = COORD_W + CNT_W;
    localparam int STEP_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int R2_W    = 2 * DIFF_W;
    localparam int HALF_W  = R2_W / 2;

    // Pi in Q2.16 and the area product
    localparam int PI_W    = 18;
    localparam int PI_FRAC = 16;
    localparam logic [PI_W-1:0] PI_Q16 = PI_W'(205887);
    localparam int PP_W    = HALF_W + PI_W;
    localparam int PROD_W  = R2_W + PI_W;

    // Result field widths
    localparam int AREA_W      = 43;
    localparam int COUNT_OUT_W = 7;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // Input item
    typedef struct packed {
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic                      last_point;
    } t_point_in;

    // Classified item: keep is low when the store is already full
    typedef struct packed {
        logic signed [COORD_W-1:0] x_pos;
        logic signed [COORD_W-1:0] y_pos;
        logic                      last_point;
        logic                      keep;
    } t_cls_item;

    // Result item
    typedef struct packed {
        logic [AREA_W-1:0]      area;
        logic [COUNT_OUT_W-1:0] point_count;
        logic                   overflowed;
    } t_result;

endpackage

[rtl/centroid_max_radius_area.sv]
// A point passes the combinational front into the registered queue; the back part loads
// one point per cycle while in ST_LOAD with the queue not empty. After the last point of
// a set: bit-serial division for SUM_W (27) quotient bits, a walk of the point store
// through the radius pipeline, the pi product in ST_MUL1 and ST_MUL2; the back part takes
// no point during that. Reset (synchronous, active low) empties the queue and result
// register and clears sums and counts; the point store is not cleared.
module centroid_max_radius_area (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cmra_pkg::t_point_in  i_item,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output cmra_pkg::t_result    o_result
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    cmra_pkg::t_cls_item  q_in;
    cmra_pkg::t_cls_item  q_out;

    // Classify incoming points
    cmra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_q_push (q_push),
        .o_q_item (q_in),
        .i_q_full (q_full)
    );

    // Decouple front from back
    cmra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    // Store, divide, walk and scale
    cmra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .o_empty   (o_empty),
        .i_pop     (i_pop)
    );

endmodule

[rtl/cmra_front.sv]
// Front part: accepts points and marks those that fit in the point store.
// Depends on cmra_pkg.
module cmra_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cmra_pkg::t_point_in  i_item,
    output logic                 o_full,
    output logic                 o_q_push,
    output cmra_pkg::t_cls_item  o_q_item,
    input  logic                 i_q_full
);

    logic [cmra_pkg::CNT_W-1:0] r_cnt;
    logic [cmra_pkg::CNT_W-1:0] n_cnt;
    logic                       accept;
    logic                       keep;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign keep     = (r_cnt < cmra_pkg::MAX_CNT);
    assign o_q_push = accept;

    // Classify the item for the back part
    always_comb begin
        o_q_item.x_pos      = i_item.x_pos;
        o_q_item.y_pos      = i_item.y_pos;
        o_q_item.last_point = i_item.last_point;
        o_q_item.keep       = keep;
    end

    // Track stored points of the current set; restart after the last one
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_item.last_point) begin
                n_cnt = '0;
            end else if (keep) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/cmra_queue.sv]
// Short queue of classified items between front and back.
// Depends on cmra_pkg.
module cmra_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cmra_pkg::t_cls_item  i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output cmra_pkg::t_cls_item  o_item,
    output logic                 o_empty
);

    cmra_pkg::t_cls_item         r_slot [cmra_pkg::QDEPTH];
    logic [cmra_pkg::QPTR_W:0]   r_wr_ptr;
    logic [cmra_pkg::QPTR_W:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[cmra_pkg::QPTR_W] != r_rd_ptr[cmra_pkg::QPTR_W]) &&
                     (r_wr_ptr[cmra_pkg::QPTR_W-1:0] == r_rd_ptr[cmra_pkg::QPTR_W-1:0]);
    assign o_item  = r_slot[r_rd_ptr[cmra_pkg::QPTR_W-1:0]];

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr[cmra_pkg::QPTR_W-1:0]] <= i_item;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[rtl/cmra_back.sv]
// Back part: stores points, sums them, divides for the centroid, walks the store
// for the largest squared radius and scales it by pi. Depends on cmra_pkg.
module cmra_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmra_pkg::t_cls_item  i_q_item,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    output cmra_pkg::t_result    o_result,
    output logic                 o_empty,
    input  logic                 i_pop
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CENT = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_MUL1 = 3'd5;
    localparam logic [2:0] ST_MUL2 = 3'd6;

    localparam int CW = cmra_pkg::CNT_W;
    localparam int SW = cmra_pkg::SUM_W;
    localparam int XW = cmra_pkg::COORD_W;
    localparam int DW = cmra_pkg::DIFF_W;

    logic [2:0]                     r_state;

    // Set state
    logic signed [SW-1:0]           r_sum_x;
    logic signed [SW-1:0]           r_sum_y;
    logic [CW-1:0]                  r_cnt;
    logic                           r_ovf;

    // Point store
    logic [2*XW-1:0]                r_mem [cmra_pkg::MAX_POINTS];
    logic [2*XW-1:0]                r_rd;

    // Divider
    logic [SW-1:0]                  r_dq_x;
    logic [SW-1:0]                  r_dq_y;
    logic [CW-1:0]                  r_rem_x;
    logic [CW-1:0]                  r_rem_y;
    logic                           r_sg_x;
    logic                           r_sg_y;
    logic [cmra_pkg::STEP_W-1:0]    r_step;
    logic [CW:0]                    trial_x;
    logic [CW:0]                    trial_y;
    logic                           ge_x;
    logic                           ge_y;
    logic [CW:0]                    sub_x;
    logic [CW:0]                    sub_y;

    // Centroid and walk pipeline
    logic signed [XW-1:0]           r_cx;
    logic signed [XW-1:0]           r_cy;
    logic [CW-1:0]                  r_iss;
    logic                           r_p1_vld;
    logic                           r_p2_vld;
    logic                           r_p3_vld;
    logic signed [DW-1:0]           r_dx;
    logic signed [DW-1:0]           r_dy;
    logic [cmra_pkg::SQ_W-1:0]      r_sqx;
    logic [cmra_pkg::SQ_W-1:0]      r_sqy;
    logic signed [2*DW-1:0]         sq_x_full;
    logic signed [2*DW-1:0]         sq_y_full;
    logic [cmra_pkg::R2_W-1:0]      r2;
    logic [cmra_pkg::R2_W-1:0]      r_best;
    logic                           issue;
    logic signed [XW-1:0]           rd_x;
    logic signed [XW-1:0]           rd_y;

    // Area product
    logic [cmra_pkg::PP_W-1:0]      r_pp_lo;
    logic [cmra_pkg::PP_W-1:0]      r_pp_hi;
    logic [cmra_pkg::PROD_W-1:0]    prod;

    // Result register
    logic                           r_res_vld;
    cmra_pkg::t_result              r_res;
    logic                           res_load;

    logic                           take;

    assign take    = (r_state == ST_LOAD) && !i_q_empty;
    assign o_q_pop = take;

    // Write point store
    always_ff @(posedge i_clk) begin
        if (take && i_q_item.keep) begin
            r_mem[r_cnt[cmra_pkg::ADDR_W-1:0]] <= {i_q_item.x_pos, i_q_item.y_pos};
        end
    end

    // Read point store during the walk
    assign issue = (r_state == ST_WALK) && (r_iss < r_cnt);
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_iss[cmra_pkg::ADDR_W-1:0]];
    end

    // One restoring division step per lane
    always_comb begin
        trial_x = {r_rem_x, r_dq_x[SW-1]};
        trial_y = {r_rem_y, r_dq_y[SW-1]};
        ge_x    = (trial_x >= {1'b0, r_cnt});
        ge_y    = (trial_y >= {1'b0, r_cnt});
        sub_x   = ge_x ? (trial_x - {1'b0, r_cnt}) : trial_x;
        sub_y   = ge_y ? (trial_y - {1'b0, r_cnt}) : trial_y;
    end

    // Radius datapath
    assign rd_x      = r_rd[2*XW-1:XW];
    assign rd_y      = r_rd[XW-1:0];
    assign sq_x_full = r_dx * r_dx;
    assign sq_y_full = r_dy * r_dy;
    assign r2        = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Combine partial products of best * pi
    assign prod = {r_pp_hi, cmra_pkg::HALF_W'(0)} + cmra_pkg::PROD_W'(r_pp_lo);

    assign res_load = (r_state == ST_MUL2) && (!r_res_vld || i_pop);

    // Walk pipeline stages and pi partial products
    always_ff @(posedge i_clk) begin
        r_dx    <= DW'(rd_x) - DW'(r_cx);
        r_dy    <= DW'(rd_y) - DW'(r_cy);
        r_sqx   <= sq_x_full[cmra_pkg::SQ_W-1:0];
        r_sqy   <= sq_y_full[cmra_pkg::SQ_W-1:0];
        r_pp_lo <= cmra_pkg::PP_W'(r_best[cmra_pkg::HALF_W-1:0]) *
                   cmra_pkg::PP_W'(cmra_pkg::PI_Q16);
        r_pp_hi <= cmra_pkg::PP_W'(r_best[cmra_pkg::R2_W-1:cmra_pkg::HALF_W]) *
                   cmra_pkg::PP_W'(cmra_pkg::PI_Q16);
    end

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res.area        <= prod[cmra_pkg::PI_FRAC +: cmra_pkg::AREA_W];
            r_res.point_count <= cmra_pkg::COUNT_OUT_W'(r_cnt);
            r_res.overflowed  <= r_ovf;
        end
    end
    assign o_result = r_res;
    assign o_empty  = !r_res_vld;

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_res_vld <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_step    <= '0;
            r_iss     <= '0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;

            if (res_load) begin
                r_res_vld <= 1'b1;
            end else if (i_pop) begin
                r_res_vld <= 1'b0;
            end

            unique case (r_state)
                ST_LOAD: begin
                    // Accumulate or drop the next point
                    if (take) begin
                        if (i_q_item.keep) begin
                            r_sum_x <= r_sum_x + SW'(i_q_item.x_pos);
                            r_sum_y <= r_sum_y + SW'(i_q_item.y_pos);
                            r_cnt   <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_q_item.last_point) begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    // Load divider with magnitudes of the sums
                    r_sg_x  <= r_sum_x[SW-1];
                    r_sg_y  <= r_sum_y[SW-1];
                    r_dq_x  <= r_sum_x[SW-1] ? SW'(-r_sum_x) : SW'(r_sum_x);
                    r_dq_y  <= r_sum_y[SW-1] ? SW'(-r_sum_y) : SW'(r_sum_y);
                    r_rem_x <= '0;
                    r_rem_y <= '0;
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // One quotient bit per cycle on each axis
                    r_rem_x <= sub_x[CW-1:0];
                    r_rem_y <= sub_y[CW-1:0];
                    r_dq_x  <= {r_dq_x[SW-2:0], ge_x};
                    r_dq_y  <= {r_dq_y[SW-2:0], ge_y};
                    r_step  <= r_step + 1'b1;
                    if (r_step == cmra_pkg::STEP_W'(SW - 1)) begin
                        r_state <= ST_CENT;
                    end
                end
                ST_CENT: begin
                    // Restore sign: truncation toward zero
                    r_cx    <= r_sg_x ? -r_dq_x[XW-1:0] : r_dq_x[XW-1:0];
                    r_cy    <= r_sg_y ? -r_dq_y[XW-1:0] : r_dq_y[XW-1:0];
                    r_iss   <= '0;
                    r_best  <= '0;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    // Issue reads, keep the running maximum, drain the pipeline
                    if (issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (r_p3_vld && (r2 > r_best)) begin
                        r_best <= r2;
                    end
                    if (!issue && !r_p1_vld && !r_p2_vld && !r_p3_vld) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    // Emit the result and clear the set
                    if (res_load) begin
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

[sim/centroid_max_radius_area_test.sv]
// Self-checking testbench for centroid_max_radius_area: point sets go in, area results come out.
// Holds its own predictor of centroid, widest squared radius and pi-scaled area.
// Depends on rtl/cmra_pkg.sv and rtl/centroid_max_radius_area.sv.
module centroid_max_radius_area_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cmra_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_SETS   = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int COORD_MAX     = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN     = -(2 ** (COORD_W - 1));
    localparam int FULL_RANGE    = -1;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_push  = 1'b0;
    t_point_in i_item  = '0;
    logic      o_full;
    logic      o_empty;
    logic      i_pop   = 1'b0;
    t_result   o_result;

    // Predictor state for the set being collected
    logic signed [COORD_W-1:0] held_x [MAX_POINTS];
    logic signed [COORD_W-1:0] held_y [MAX_POINTS];
    longint  acc_x       = 0;
    longint  acc_y       = 0;
    int      pts_held    = 0;
    bit      pts_dropped = 1'b0;
    t_result pending_areas[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int drain_hold  = 0;
    bit feed_gaps   = 1'b0;
    bit drain_gaps  = 1'b0;

    centroid_max_radius_area dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Store and sum one point; on the last point compute the expected area
    function automatic void take_point(t_point_in p);
        longint          cx;
        longint          cy;
        longint          dx;
        longint          dy;
        longint unsigned r2;
        longint unsigned widest;
        t_result         res;
        if (pts_held < MAX_POINTS) begin
            held_x[pts_held] = p.x_pos;
            held_y[pts_held] = p.y_pos;
            acc_x += p.x_pos;
            acc_y += p.y_pos;
            pts_held++;
        end else begin
            pts_dropped = 1'b1;
        end
        if (p.last_point) begin
            // signed division truncates toward zero
            cx = acc_x / pts_held;
            cy = acc_y / pts_held;
            widest = 0;
            for (int i = 0; i < pts_held; i++) begin
                dx = held_x[i] - cx;
                dy = held_y[i] - cy;
                r2 = dx * dx + dy * dy;
                if (r2 > widest) begin
                    widest = r2;
                end
            end
            res.area        = AREA_W'((widest * 64'(PI_Q16)) >> PI_FRAC);
            res.point_count = COUNT_OUT_W'(pts_held);
            res.overflowed  = pts_dropped;
            pending_areas   = {pending_areas, res};
            acc_x       = 0;
            acc_y       = 0;
            pts_held    = 0;
            pts_dropped = 1'b0;
        end
    endfunction

    // Predict on every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            take_point(i_item);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_areas.size() == 0) begin
                $display("%0t: unexpected result, expected none, got area %0d count %0d ovf %0b",
                         $time, o_result.area, o_result.point_count, o_result.overflowed);
                mismatches++;
            end else begin
                want = pending_areas.pop_front();
                if (o_result.area !== want.area) begin
                    $display("%0t: area mismatch, expected %0d, got %0d",
                             $time, want.area, o_result.area);
                    mismatches++;
                end
                if (o_result.point_count !== want.point_count) begin
                    $display("%0t: point_count mismatch, expected %0d, got %0d",
                             $time, want.point_count, o_result.point_count);
                    mismatches++;
                end
                if (o_result.overflowed !== want.overflowed) begin
                    $display("%0t: overflowed mismatch, expected %0b, got %0b",
                             $time, want.overflowed, o_result.overflowed);
                    mismatches++;
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (drain_hold > 0) begin
                i_pop <= 1'b0;
                repeat (drain_hold) @(posedge i_clk);
                drain_hold = 0;
            end
            gap = drain_gaps ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty && drain_hold == 0) @(posedge i_clk);
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(int center, int spread);
        int v;
        if (spread < 0) begin
            return COORD_W'($urandom);
        end
        v = $urandom_range(0, 2 * spread);
        return COORD_W'(center + v - spread);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic last);
        int        gap;
        t_point_in pt;
        gap = feed_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt.x_pos      = x;
        pt.y_pos      = y;
        pt.last_point = last;
        i_push <= 1'b1;
        i_item <= pt;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        items_sent++;
    endtask

    // Send a set of n points around a random center within spread (full range if negative)
    task automatic send_set(int n, int spread);
        int cx;
        int cy;
        cx = int'(rand_coord(0, FULL_RANGE));
        cy = int'(rand_coord(0, FULL_RANGE));
        for (int i = 0; i < n; i++) begin
            send_point(rand_coord(cx, spread), rand_coord(cy, spread), i == n - 1);
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_drain();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending_areas.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, truncation toward zero, degenerate sets
    task automatic test_directed();
        feed_gaps  = 1'b0;
        drain_gaps = 1'b0;
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        // negative sums that do not divide evenly
        send_point(-1, -2, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(-1, 0, 1'b1);
        send_point(5, 7, 1'b0);
        send_point(0, 0, 1'b1);
        // identical points give zero area
        send_point(12345, -6789, 1'b0);
        send_point(12345, -6789, 1'b0);
        send_point(12345, -6789, 1'b1);
        // alternating bit patterns
        send_point(20'h55555, 20'hAAAAA, 1'b0);
        send_point(20'hAAAAA, 20'h55555, 1'b1);
        send_point(0, 0, 1'b1);
        wait_drain();
    endtask

    // Fill the store exactly, then overrun it, then check the flag clears
    task automatic test_store_full();
        feed_gaps  = 1'b1;
        drain_gaps = 1'b1;
        send_set(MAX_POINTS, FULL_RANGE);
        send_set(MAX_POINTS + 1, FULL_RANGE);
        send_set(MAX_POINTS + 6, 4096);
        send_set(1, FULL_RANGE);
        wait_drain();
    endtask

    // Hold off the result side so the block fills and stalls its input
    task automatic test_backpressure();
        feed_gaps  = 1'b0;
        drain_gaps = 1'b0;
        drain_hold = HOLD_CYCLES;
        repeat (15) send_set(2, FULL_RANGE);
        wait_drain();
    endtask

    // Random sets of mostly small sizes, random spreads and idling
    task automatic test_random();
        int start;
        int sets;
        int pick;
        int n;
        int spread;
        start = items_sent;
        sets  = 0;
        while (items_sent - start < RANDOM_ITEMS || sets < RANDOM_SETS) begin
            feed_gaps  = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                n = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
            end else if (pick < 4) begin
                n = $urandom_range(9, 30);
            end else begin
                n = $urandom_range(1, 8);
            end
            case ($urandom_range(0, 3))
                0:       spread = FULL_RANGE;
                1:       spread = 4096;
                2:       spread = 16;
                default: spread = 0;
            endcase
            send_set(n, spread);
            sets++;
        end
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
